@@ rtl/mtf_pkg.sv @@
package mtf_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = 5;
   localparam int KEY_W = 16;
   localparam int VAL_W = 32;

   // action codes
   localparam logic [1:0] ACT_INS_FRONT  = 2'd0;
   localparam logic [1:0] ACT_INS_SORTED = 2'd1;
   localparam logic [1:0] ACT_LOOKUP     = 2'd2;
   localparam logic [1:0] ACT_CLEAR      = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // order list operations
   localparam logic [1:0] ORD_NONE   = 2'd0;
   localparam logic [1:0] ORD_INSERT = 2'd1;
   localparam logic [1:0] ORD_ROTATE = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] pos;
      logic [CNT_W-1:0] fill;
      logic [IDX_W-1:0] idx;
   } ord_cmd_type;

endpackage

@@ rtl/mtf_store.sv @@
module mtf_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [mtf_pkg::IDX_W-1:0]   wr_addr,
   input  logic [mtf_pkg::KEY_W-1:0]   wr_key,
   input  logic [mtf_pkg::VAL_W-1:0]   wr_val,
   input  logic [mtf_pkg::IDX_W-1:0]   rd_addr,
   output logic [mtf_pkg::KEY_W-1:0]   rd_key,
   output logic [mtf_pkg::VAL_W-1:0]   rd_val
);
   import mtf_pkg::*;

   logic [KEY_W-1:0] mem_key [DEPTH];
   logic [VAL_W-1:0] mem_val [DEPTH];

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_key[wr_addr] <= wr_key;
         mem_val[wr_addr] <= wr_val;
      end
      rd_key <= mem_key[rd_addr];
      rd_val <= mem_val[rd_addr];
   end

endmodule

@@ rtl/mtf_order.sv @@
module mtf_order (
   input  logic                        clock,
   input  logic                        reset,
   input  mtf_pkg::ord_cmd_type        cmd,
   input  logic [mtf_pkg::IDX_W-1:0]   rd_addr,
   output logic [mtf_pkg::IDX_W-1:0]   rd_data
);
   import mtf_pkg::*;

   // logical position -> physical slot, always a permutation
   logic [IDX_W-1:0] ord_ff [DEPTH];
   logic [IDX_W-1:0] ord_in [DEPTH];

   assign rd_data = ord_ff[rd_addr];

   // insert opens a gap at pos, rotate brings pos to the front
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         ord_in[j] = ord_ff[j];
         unique case (cmd.op)
            ORD_INSERT: begin
               if (IDX_W'(j) == cmd.pos) begin
                  ord_in[j] = cmd.idx;
               end else if (IDX_W'(j) > cmd.pos && CNT_W'(j) <= cmd.fill && j > 0) begin
                  ord_in[j] = ord_ff[(j > 0) ? j - 1 : 0];
               end
            end
            ORD_ROTATE: begin
               if (j == 0) begin
                  ord_in[j] = cmd.idx;
               end else if (IDX_W'(j) <= cmd.pos) begin
                  ord_in[j] = ord_ff[(j > 0) ? j - 1 : 0];
               end
            end
            default: ord_in[j] = ord_ff[j];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         if (reset) begin
            ord_ff[j] <= IDX_W'(j);
         end else begin
            ord_ff[j] <= ord_in[j];
         end
      end
   end

endmodule

@@ rtl/move_to_front_table.sv @@
// clear, full-table inserts and lookups in an empty table go from idle straight to the done state
// front inserts and inserts into an empty table use the write state; lookups scan until a hit
// or the end; sorted inserts check the head, then the tail if needed, then scan from position 1
// one transaction at a time, taken only in idle; each read is address, then registered data
// reset: table empty, order list set to identity; memory contents not cleared
module move_to_front_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,  // key[15:0], value[47:16]
   input  logic [1:0]   req_tuser,  // action[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,  // read_value[31:0], entries_held[36:32], zero fill
   output logic [1:0]   rsp_tuser   // status[1:0]
);
   import mtf_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD    = 3'd1;
   localparam logic [2:0] S_CMP   = 3'd2;
   localparam logic [2:0] S_WRITE = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam logic [1:0] PH_SCAN = 2'd0;
   localparam logic [1:0] PH_HEAD = 2'd1;
   localparam logic [1:0] PH_TAIL = 2'd2;
   localparam logic [1:0] PH_GE   = 2'd3;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [1:0]       act_ff, act_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic [1:0]       res_st_ff, res_st_in;
   logic [VAL_W-1:0] res_val_ff, res_val_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_st_ff, rsp_st_in;
   logic [VAL_W-1:0] rsp_val_ff, rsp_val_in;
   logic [CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic [IDX_W-1:0] ord_addr, ord_data;
   logic [KEY_W-1:0] rd_key;
   logic [VAL_W-1:0] rd_val;
   logic             wr_en;
   ord_cmd_type      ord_cmd;
   logic             req_acc;
   logic [CNT_W-1:0] pos_next;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign pos_next   = pos_ff + CNT_W'(1);
   assign ord_addr   = (state_ff == S_IDLE) ? fill_ff[IDX_W-1:0] : pos_ff[IDX_W-1:0];
   assign wr_en      = (state_ff == S_WRITE);

   mtf_order u_order (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ord_cmd),
      .rd_addr (ord_addr),
      .rd_data (ord_data)
   );

   mtf_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_ff),
      .wr_key  (key_ff),
      .wr_val  (val_ff),
      .rd_addr (ord_data),
      .rd_key  (rd_key),
      .rd_val  (rd_val)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      act_in     = act_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      fill_in    = fill_ff;
      pos_in     = pos_ff;
      free_in    = free_ff;
      res_st_in  = res_st_ff;
      res_val_in = res_val_ff;
      ord_cmd    = '{op: ORD_NONE, pos: pos_ff[IDX_W-1:0], fill: fill_ff, idx: ord_data};
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               act_in     = req_tuser;
               key_in     = req_tdata[15:0];
               val_in     = req_tdata[47:16];
               free_in    = ord_data;
               pos_in     = '0;
               res_st_in  = ST_OK;
               res_val_in = '0;
               unique case (req_tuser)
                  ACT_CLEAR: begin
                     fill_in  = '0;
                     state_in = S_DONE;
                  end
                  ACT_LOOKUP: begin
                     phase_in = PH_SCAN;
                     if (fill_ff == '0) begin
                        res_st_in = ST_MISS;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     phase_in = PH_HEAD;
                     if (fill_ff >= CNT_W'(DEPTH)) begin
                        res_st_in = ST_FULL;
                        state_in  = S_DONE;
                     end else if (req_tuser == ACT_INS_FRONT || fill_ff == '0) begin
                        state_in = S_WRITE;
                     end else begin
                        state_in = S_RD;
                     end
                  end
               endcase
            end
         end
         S_RD: state_in = S_CMP;
         S_CMP: begin
            state_in = S_RD;
            unique case (phase_ff)
               PH_SCAN: begin
                  if (rd_key == key_ff) begin
                     ord_cmd.op = ORD_ROTATE;
                     res_val_in = rd_val;
                     state_in   = S_DONE;
                  end else if (pos_next == fill_ff) begin
                     res_st_in = ST_MISS;
                     state_in  = S_DONE;
                  end else begin
                     pos_in = pos_next;
                  end
               end
               PH_HEAD: begin
                  if (rd_key >= key_ff) begin
                     state_in = S_WRITE;
                  end else if (fill_ff == CNT_W'(1)) begin
                     pos_in   = fill_ff;
                     state_in = S_WRITE;
                  end else begin
                     pos_in   = fill_ff - CNT_W'(1);
                     phase_in = PH_TAIL;
                  end
               end
               PH_TAIL: begin
                  if (rd_key <= key_ff) begin
                     pos_in   = fill_ff;
                     state_in = S_WRITE;
                  end else begin
                     pos_in   = CNT_W'(1);
                     phase_in = PH_GE;
                  end
               end
               default: begin
                  if (rd_key >= key_ff) begin
                     state_in = S_WRITE;
                  end else begin
                     pos_in = pos_next;
                  end
               end
            endcase
         end
         S_WRITE: begin
            ord_cmd.op  = ORD_INSERT;
            ord_cmd.idx = free_ff;
            fill_in     = fill_ff + CNT_W'(1);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_st_in    = rsp_st_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_st_in    = res_st_ff;
         rsp_val_in   = res_val_ff;
         rsp_cnt_in   = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff   <= phase_in;
      act_ff     <= act_in;
      key_ff     <= key_in;
      val_ff     <= val_in;
      pos_ff     <= pos_in;
      free_ff    <= free_in;
      res_st_ff  <= res_st_in;
      res_val_ff <= res_val_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = {3'b000, rsp_cnt_ff, rsp_val_ff};

   // checks
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != S_IDLE)
      else $error("accepted transaction did not start");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> fill_ff < CNT_W'(DEPTH))
      else $error("write into a full table");

   a_rotate_hit: assert property (@(posedge clock) disable iff (reset)
      ord_cmd.op == ORD_ROTATE |-> act_ff == ACT_LOOKUP && rd_key == key_ff)
      else $error("reorder without a lookup hit");

endmodule
